// ===== design/hds_pkg.sv =====
// Shared types and constants of the heat diffusion stencil step core.
`default_nettype none

package hds_pkg;

    localparam int SAMPLE_BITS     = 16;
    localparam int MAX_WIDTH_DEF   = 64;
    localparam int ROW_W           = 12;
    localparam int COL_OUT_W       = 6;
    localparam int CFG_WIDTH_BITS  = 7;
    localparam int CFG_HEIGHT_BITS = 13;
    localparam int GAIN_BITS       = 16;
    localparam int CFG_DATA_W      = 16;
    localparam int CFG_INDEX_W     = 2;

    localparam int WIDTH_RESET     = 12;
    localparam int HEIGHT_RESET    = 12;
    localparam int GAIN_RESET      = 983;

    localparam int W_MIN           = 3;
    localparam int H_MIN           = 3;
    localparam int H_MAX           = 4096;

    localparam int FRAC_BITS       = 16;
    localparam int LAP_W           = SAMPLE_BITS + 3;
    localparam int PROD_W          = LAP_W + GAIN_BITS + 1;
    localparam int DELTA_W         = PROD_W - FRAC_BITS;
    localparam int SUM_W           = DELTA_W + 1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_GRID_WIDTH     = 2'd0,
        CFG_GRID_HEIGHT    = 2'd1,
        CFG_DIFFUSION_GAIN = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] temperature;
        logic                          frame_start;
    } t_hds_in;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] new_temperature;
        logic [ROW_W-1:0]              cell_row;
        logic [COL_OUT_W-1:0]          cell_column;
        logic                          frame_done;
    } t_hds_out;

    typedef struct packed {
        logic [ROW_W-1:0]     cell_row;
        logic [COL_OUT_W-1:0] cell_column;
        logic                 frame_done;
    } t_hds_tag;

    // One line buffer entry: row r-1 and row r-2 of the same column.
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] prev;
        logic signed [SAMPLE_BITS-1:0] older;
    } t_lb_word;

endpackage

`default_nettype wire

// ===== design/hds_cell.sv =====
// One window cell: a sample register that takes its neighbour's value on shift.
`default_nettype none

module hds_cell #(
    parameter int WIDTH = hds_pkg::SAMPLE_BITS
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_shift,
    input  wire logic signed [WIDTH-1:0] i_d,
    output logic signed [WIDTH-1:0]      o_q
);
    import hds_pkg::*;

    logic signed [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else if (i_shift) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

`default_nettype wire

// ===== design/hds_window.sv =====
// Stencil window: a chain of cells for the middle row, single cells above and below.
`default_nettype none

module hds_window (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_shift,
    input  wire logic signed [hds_pkg::SAMPLE_BITS-1:0] i_mid,
    input  wire logic signed [hds_pkg::SAMPLE_BITS-1:0] i_upper,
    input  wire logic signed [hds_pkg::SAMPLE_BITS-1:0] i_lower,
    output logic signed [hds_pkg::SAMPLE_BITS-1:0]      o_center,
    output logic signed [hds_pkg::SAMPLE_BITS-1:0]      o_left,
    output logic signed [hds_pkg::SAMPLE_BITS-1:0]      o_up,
    output logic signed [hds_pkg::SAMPLE_BITS-1:0]      o_down
);
    import hds_pkg::*;

    localparam int MID_TAPS = 2;

    logic signed [SAMPLE_BITS-1:0] w_mid [MID_TAPS+1];

    assign w_mid[0] = i_mid;

    // middle row: column c-1 then c-2
    for (genvar g = 0; g < MID_TAPS; g++) begin : g_mid
        hds_cell #(.WIDTH(SAMPLE_BITS)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (i_shift),
            .i_d     (w_mid[g]),
            .o_q     (w_mid[g+1])
        );
    end

    hds_cell #(.WIDTH(SAMPLE_BITS)) u_up (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (i_shift),
        .i_d     (i_upper),
        .o_q     (o_up)
    );

    hds_cell #(.WIDTH(SAMPLE_BITS)) u_down (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (i_shift),
        .i_d     (i_lower),
        .o_q     (o_down)
    );

    assign o_center = w_mid[1];
    assign o_left   = w_mid[2];

endmodule

`default_nettype wire

// ===== design/hds_line_buffer.sv =====
// Column-addressed line buffer holding rows r-1 and r-2, with write-to-read bypass.
`default_nettype none

module hds_line_buffer #(
    parameter int DEPTH = hds_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_en,
    input  wire logic                                   i_rd_accept,
    input  wire logic [$clog2(DEPTH)-1:0]               i_rd_addr,
    input  wire logic                                   i_wr_valid,
    input  wire logic [$clog2(DEPTH)-1:0]               i_wr_addr,
    input  wire logic signed [hds_pkg::SAMPLE_BITS-1:0] i_wr_sample,
    output logic signed [hds_pkg::SAMPLE_BITS-1:0]      o_prev,
    output logic signed [hds_pkg::SAMPLE_BITS-1:0]      o_older
);
    import hds_pkg::*;

    localparam int AW = $clog2(DEPTH);

    t_lb_word r_mem [DEPTH];
    t_lb_word r_rd;
    t_lb_word r_fwd_word;
    logic     r_fwd_hit;
    t_lb_word w_word;
    t_lb_word w_wr_word;

    // read and write share the edge; a same-column pair is bypassed
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rd <= r_mem[i_rd_addr];
        end
        if (i_en && i_wr_valid) begin
            r_mem[i_wr_addr] <= w_wr_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
        end else if (i_en) begin
            r_fwd_hit <= i_rd_accept && i_wr_valid && (i_rd_addr == i_wr_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fwd_word <= w_wr_word;
        end
    end

    assign w_word          = r_fwd_hit ? r_fwd_word : r_rd;
    assign w_wr_word.prev  = i_wr_sample;
    assign w_wr_word.older = w_word.prev;

    assign o_prev  = w_word.prev;
    assign o_older = w_word.older;

endmodule

`default_nettype wire

// ===== design/hds_update.sv =====
// Update datapath: Laplacian, gain multiply with rounding, add and saturate.
`default_nettype none

module hds_update (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_en,
    input  wire logic                                   i_valid,
    input  wire logic signed [hds_pkg::SAMPLE_BITS-1:0] i_center,
    input  wire logic signed [hds_pkg::SAMPLE_BITS-1:0] i_left,
    input  wire logic signed [hds_pkg::SAMPLE_BITS-1:0] i_right,
    input  wire logic signed [hds_pkg::SAMPLE_BITS-1:0] i_up,
    input  wire logic signed [hds_pkg::SAMPLE_BITS-1:0] i_down,
    input  wire hds_pkg::t_hds_tag                      i_tag,
    input  wire logic [hds_pkg::GAIN_BITS-1:0]          i_gain,
    output logic                                        o_valid,
    output hds_pkg::t_hds_out                           o_data
);
    import hds_pkg::*;

    localparam logic signed [PROD_W-1:0] ROUND_K = PROD_W'(1 << (FRAC_BITS - 1));
    localparam logic signed [SUM_W-1:0]  SAT_HI  = SUM_W'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [SUM_W-1:0]  SAT_LO  = -SAT_HI - SUM_W'(1);

    logic                          r_a_valid;
    logic signed [LAP_W-1:0]       r_a_lap;
    logic signed [SAMPLE_BITS-1:0] r_a_center;
    t_hds_tag                      r_a_tag;

    logic                          r_b_valid;
    logic signed [DELTA_W-1:0]     r_b_delta;
    logic signed [SAMPLE_BITS-1:0] r_b_center;
    t_hds_tag                      r_b_tag;

    logic signed [LAP_W-1:0]  w_lap;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [PROD_W-1:0] w_round;
    logic signed [SUM_W-1:0]  w_sum;
    logic signed [SAMPLE_BITS-1:0] w_sat;

    // exact sum; the widths leave room for the extremes
    assign w_lap = LAP_W'(i_left) + LAP_W'(i_right) + LAP_W'(i_up) + LAP_W'(i_down)
                 - (LAP_W'(i_center) <<< 2);

    assign w_prod  = $signed({1'b0, i_gain}) * r_a_lap;
    assign w_round = w_prod + ROUND_K;

    assign w_sum = SUM_W'(r_b_center) + SUM_W'(r_b_delta);

    always_comb begin
        if (w_sum > SAT_HI) begin
            w_sat = SAT_HI[SAMPLE_BITS-1:0];
        end else if (w_sum < SAT_LO) begin
            w_sat = SAT_LO[SAMPLE_BITS-1:0];
        end else begin
            w_sat = w_sum[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_lap    <= w_lap;
            r_a_center <= i_center;
            r_a_tag    <= i_tag;
            r_b_delta  <= w_round[PROD_W-1:FRAC_BITS];
            r_b_center <= r_a_center;
            r_b_tag    <= r_a_tag;
        end
    end

    assign o_valid                = r_b_valid;
    assign o_data.new_temperature = w_sat;
    assign o_data.cell_row        = r_b_tag.cell_row;
    assign o_data.cell_column     = r_b_tag.cell_column;
    assign o_data.frame_done      = r_b_tag.frame_done;

endmodule

`default_nettype wire

// ===== design/heat_diffusion_stencil_step_core.sv =====
// Top level of the five-point explicit heat step on a raster stream of grid cells.
//
// Usage:
// - Input channel (i_in_valid/o_in_ready/i_in_data) takes one cell per transaction
//   in raster order; frame_start marks row 0, column 0 of a new time step.
// - Output channel (o_out_valid/i_out_ready/o_out_data) returns one transaction per
//   interior cell, one row and one column behind the input; frame_done flags the
//   last interior cell. Boundary cells give no output.
// - Configuration channel (i_cfg_valid/o_cfg_ready/i_cfg_index/i_cfg_data) sets
//   width, height and gain; always ready, but it must be written only between
//   transactions, which the block does not enforce. Throughput: one cell per clock
//   while results are taken. The line buffer read shares the accepting edge; then
//   Laplacian, gain multiply, and add and saturate each end in a register.
// Stall: the whole pipeline holds while the output register is full and not taken;
//   o_in_ready follows from that, so no transaction is ever dropped.
// Reset: clears counters, valid flags, window and config (12 x 12, gain 983).
//   The line buffer memory is not cleared; rows 0 and 1 of each frame fill it.
`default_nettype none

module heat_diffusion_stencil_step_core #(
    parameter int MAX_WIDTH = hds_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire hds_pkg::t_hds_in                 i_in_data,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output hds_pkg::t_hds_out                     o_out_data,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [hds_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  wire logic [hds_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import hds_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    // compare width wide enough for both the register and the maximum
    localparam int WX    = (COL_W + 1 > CFG_WIDTH_BITS) ? COL_W + 1 : CFG_WIDTH_BITS;

    // configuration registers
    logic [CFG_WIDTH_BITS-1:0]  r_grid_width;
    logic [CFG_HEIGHT_BITS-1:0] r_grid_height;
    logic [GAIN_BITS-1:0]       r_gain;

    // raster position of the next cell
    logic [COL_W-1:0] r_col_cnt, n_col_cnt;
    logic [ROW_W-1:0] r_row_cnt, n_row_cnt;

    // stage 1: cell whose line buffer read is in flight
    logic                          r_s1_valid;
    logic                          r_s1_emit;
    logic signed [SAMPLE_BITS-1:0] r_s1_cur;
    logic [COL_W-1:0]              r_s1_col;
    t_hds_tag                      r_s1_tag;

    // output register
    logic     r_out_valid;
    t_hds_out r_out_data;

    logic                 w_en;
    logic                 w_accept;
    logic [WX-1:0]        w_w_ext;
    logic [WX-1:0]        w_w_sat;
    logic [COL_W-1:0]     w_wm1;
    logic [CFG_HEIGHT_BITS-1:0] w_h_sat;
    logic [ROW_W-1:0]     w_hm1;
    logic [COL_W-1:0]     w_c0;
    logic [ROW_W-1:0]     w_r0;
    logic                 w_emit0;
    t_hds_tag             w_tag0;

    logic signed [SAMPLE_BITS-1:0] w_prev, w_older;
    logic signed [SAMPLE_BITS-1:0] w_center, w_left, w_up, w_down;
    logic                          w_upd_valid;
    t_hds_out                      w_upd_data;

    // pipeline advances unless a finished result is waiting
    assign w_en        = !r_out_valid || i_out_ready;
    assign o_in_ready  = w_en;
    assign w_accept    = i_in_valid && w_en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= CFG_WIDTH_BITS'(WIDTH_RESET);
            r_grid_height <= CFG_HEIGHT_BITS'(HEIGHT_RESET);
            r_gain        <= GAIN_BITS'(GAIN_RESET);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_GRID_WIDTH:     r_grid_width  <= i_cfg_data[CFG_WIDTH_BITS-1:0];
                CFG_GRID_HEIGHT:    r_grid_height <= i_cfg_data[CFG_HEIGHT_BITS-1:0];
                CFG_DIFFUSION_GAIN: r_gain        <= i_cfg_data[GAIN_BITS-1:0];
                default: ;
            endcase
        end
    end

    // sizes clamped to the supported range
    assign w_w_ext = WX'(r_grid_width);

    always_comb begin
        if (w_w_ext < WX'(W_MIN)) begin
            w_w_sat = WX'(W_MIN);
        end else if (w_w_ext > WX'(MAX_WIDTH)) begin
            w_w_sat = WX'(MAX_WIDTH);
        end else begin
            w_w_sat = w_w_ext;
        end
        if (r_grid_height < CFG_HEIGHT_BITS'(H_MIN)) begin
            w_h_sat = CFG_HEIGHT_BITS'(H_MIN);
        end else if (r_grid_height > CFG_HEIGHT_BITS'(H_MAX)) begin
            w_h_sat = CFG_HEIGHT_BITS'(H_MAX);
        end else begin
            w_h_sat = r_grid_height;
        end
    end

    assign w_wm1 = COL_W'(w_w_sat - WX'(1));
    assign w_hm1 = ROW_W'(w_h_sat - CFG_HEIGHT_BITS'(1));

    // position of the arriving cell; frame start forces the origin
    assign w_c0 = i_in_data.frame_start ? '0 : r_col_cnt;
    assign w_r0 = i_in_data.frame_start ? '0 : r_row_cnt;

    // centre sits one row up and one column left of the arriving cell
    assign w_emit0 = (w_r0 >= ROW_W'(2)) && (w_r0 <= w_hm1)
                  && (w_c0 >= COL_W'(2)) && (w_c0 <= w_wm1);
    assign w_tag0.cell_row    = w_r0 - ROW_W'(1);
    assign w_tag0.cell_column = COL_OUT_W'(w_c0 - COL_W'(1));
    assign w_tag0.frame_done  = (w_r0 == w_hm1) && (w_c0 == w_wm1);

    always_comb begin
        if (w_c0 >= w_wm1) begin
            n_col_cnt = '0;
            n_row_cnt = (w_r0 >= w_hm1) ? '0 : w_r0 + ROW_W'(1);
        end else begin
            n_col_cnt = w_c0 + COL_W'(1);
            n_row_cnt = w_r0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_cnt   <= '0;
            r_row_cnt   <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_col_cnt <= n_col_cnt;
                r_row_cnt <= n_row_cnt;
            end
            if (w_en) begin
                r_s1_valid  <= w_accept;
                r_out_valid <= w_upd_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_emit  <= w_emit0;
            r_s1_cur   <= i_in_data.temperature;
            r_s1_col   <= w_c0;
            r_s1_tag   <= w_tag0;
            r_out_data <= w_upd_data;
        end
    end

    hds_line_buffer #(.DEPTH(MAX_WIDTH)) u_line_buffer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_rd_accept (w_accept),
        .i_rd_addr   (w_c0),
        .i_wr_valid  (r_s1_valid),
        .i_wr_addr   (r_s1_col),
        .i_wr_sample (r_s1_cur),
        .o_prev      (w_prev),
        .o_older     (w_older)
    );

    // window shifts once per cell, after the stencil has been sampled
    hds_window u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_shift  (w_en && r_s1_valid),
        .i_mid    (w_prev),
        .i_upper  (w_older),
        .i_lower  (r_s1_cur),
        .o_center (w_center),
        .o_left   (w_left),
        .o_up     (w_up),
        .o_down   (w_down)
    );

    hds_update u_update (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (r_s1_valid && r_s1_emit),
        .i_center (w_center),
        .i_left   (w_left),
        .i_right  (w_prev),
        .i_up     (w_up),
        .i_down   (w_down),
        .i_tag    (r_s1_tag),
        .i_gain   (r_gain),
        .o_valid  (w_upd_valid),
        .o_data   (w_upd_data)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef SYNTH
    // interior cells only: never row 0 or column 0
    a_out_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_data.cell_row != '0) && (r_out_data.cell_column != '0))
        else $error("boundary cell emitted");

    // a new result only comes from the datapath
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_upd_valid))
        else $error("result appeared without datapath valid");

    // column counter stays within the line buffer
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col_cnt <= COL_W'(MAX_WIDTH - 1))
        else $error("column counter beyond line buffer depth");

    // a held result must not be overwritten
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> r_out_valid && $stable(r_out_data))
        else $error("stalled result lost");
`endif

endmodule

`default_nettype wire

// ===== verif/heat_diffusion_stencil_step_core_tb.sv =====
// Self-checking testbench for the five-point heat step core: predictor, stimulus and checks.
module heat_diffusion_stencil_step_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hds_pkg::*;

    localparam int CYCLE_LIMIT     = 400_000;
    localparam int SETTLE_CYCLES   = 12;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int RANDOM_ITEMS    = 570;
    localparam int MAX_PRINTED     = 100;
    localparam int LB_DEPTH        = MAX_WIDTH_DEF;

    // ------------------------------------------------------------------
    // Ports, all driven to known values from time zero
    // ------------------------------------------------------------------
    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_in_valid  = 1'b0;
    logic                   o_in_ready;
    t_hds_in                i_in_data   = '0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    t_hds_out               o_out_data;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data  = '0;

    heat_diffusion_stencil_step_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor state: our own copy of the line buffers, window, raster
    // position and the three registers, reset values as in the block.
    // ------------------------------------------------------------------
    logic signed [SAMPLE_BITS-1:0] lb_two_up [LB_DEPTH];   // row r-2 per column
    logic signed [SAMPLE_BITS-1:0] lb_one_up [LB_DEPTH];   // row r-1 per column
    // [0] centre, [1] left, [2] up, [3] down, all for the cell one column back
    logic signed [SAMPLE_BITS-1:0] stencil_win [4] = '{default: '0};
    int unsigned                   pos_col = 0;
    int unsigned                   pos_row = 0;
    logic [CFG_WIDTH_BITS-1:0]     cfg_cols = CFG_WIDTH_BITS'(WIDTH_RESET);
    logic [CFG_HEIGHT_BITS-1:0]    cfg_rows = CFG_HEIGHT_BITS'(HEIGHT_RESET);
    logic [GAIN_BITS-1:0]          cfg_gain = GAIN_BITS'(GAIN_RESET);

    t_hds_out expected_updates [$];

    // Flow control knobs shared by the sender, the receiver and the tests
    int sender_idle_pct   = 0;
    int receiver_idle_pct = 0;
    bit hold_off_request  = 1'b0;
    int hold_off_left     = 0;

    int cycle_count    = 0;
    int mismatch_count = 0;

    initial begin
        for (int i = 0; i < LB_DEPTH; i++) begin
            lb_two_up[i] = '0;
            lb_one_up[i] = '0;
        end
    end

    // Sizes as the block uses them: width clamped to [3, 64], height to [3, 4096].
    function automatic int eff_cols();
        int v;
        v = cfg_cols;
        if (v < W_MIN) v = W_MIN;
        if (v > MAX_WIDTH_DEF) v = MAX_WIDTH_DEF;
        return v;
    endfunction

    function automatic int eff_rows();
        int v;
        v = cfg_rows;
        if (v < H_MIN) v = H_MIN;
        if (v > H_MAX) v = H_MAX;
        return v;
    endfunction

    // centre + alpha * Laplacian. The Q19.16 product is rounded to Q19.0 by
    // adding half an LSB and flooring, so ties go towards +infinity; the sum
    // then saturates to the sample range.
    function automatic logic signed [SAMPLE_BITS-1:0] heat_update(
        input logic signed [SAMPLE_BITS-1:0] ctr,
        input logic signed [SAMPLE_BITS-1:0] lft,
        input logic signed [SAMPLE_BITS-1:0] rgt,
        input logic signed [SAMPLE_BITS-1:0] up,
        input logic signed [SAMPLE_BITS-1:0] dn
    );
        longint lap;
        longint prod;
        longint total;
        longint hi;
        longint lo;
        hi    = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
        lo    = -hi - 1;
        lap   = longint'(lft) + longint'(rgt) + longint'(up) + longint'(dn)
              - 4 * longint'(ctr);
        prod  = longint'(cfg_gain) * lap + (longint'(1) <<< (FRAC_BITS - 1));
        total = longint'(ctr) + (prod >>> FRAC_BITS);
        if (total > hi) total = hi;
        if (total < lo) total = lo;
        return SAMPLE_BITS'(total);
    endfunction

    // Advance the predictor by one accepted cell and queue the update it
    // completes, if any. A cell at (r, c) completes interior cell (r-1, c-1).
    function automatic void advance_grid(input logic [SAMPLE_BITS-1:0] temp,
                                         input logic first);
        int                            w;
        int                            h;
        int                            r;
        int                            c;
        logic signed [SAMPLE_BITS-1:0] cur;
        logic signed [SAMPLE_BITS-1:0] two_up;
        logic signed [SAMPLE_BITS-1:0] one_up;
        t_hds_out                      upd;
        w = eff_cols();
        h = eff_rows();
        if (first) begin
            pos_col = 0;
            pos_row = 0;
        end
        r      = pos_row;
        c      = pos_col;
        cur    = temp;
        two_up = lb_two_up[c];
        one_up = lb_one_up[c];
        lb_two_up[c] = one_up;
        lb_one_up[c] = cur;

        if (r >= 2 && r <= h - 1 && c >= 2 && c <= w - 1) begin
            upd.new_temperature = heat_update(stencil_win[0], stencil_win[1], one_up,
                                              stencil_win[2], stencil_win[3]);
            upd.cell_row        = ROW_W'(r - 1);
            upd.cell_column     = COL_OUT_W'(c - 1);
            upd.frame_done      = (r == h - 1 && c == w - 1);
            expected_updates    = {expected_updates, upd};
        end

        stencil_win[1] = stencil_win[0];
        stencil_win[0] = one_up;
        stencil_win[2] = two_up;
        stencil_win[3] = cur;

        // Column wraps at or past W-1, row at or past H-1: frames without a
        // start flag simply follow on from the previous one.
        if (c >= w - 1) begin
            pos_col = 0;
            pos_row = (r >= h - 1) ? 0 : r + 1;
        end else begin
            pos_col = c + 1;
        end
    endfunction

    function automatic void apply_register(input t_cfg_index idx,
                                           input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_GRID_WIDTH:     cfg_cols = data[CFG_WIDTH_BITS-1:0];
            CFG_GRID_HEIGHT:    cfg_rows = data[CFG_HEIGHT_BITS-1:0];
            CFG_DIFFUSION_GAIN: cfg_gain = data[GAIN_BITS-1:0];
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("MISMATCH cycle %0d: %s", cycle_count, what);
    endtask

    task automatic check_update(input t_hds_out got);
        t_hds_out want;
        if (expected_updates.size() == 0) begin
            report_mismatch($sformatf("update row %0d column %0d with none expected",
                                      got.cell_row, got.cell_column));
            return;
        end
        want = expected_updates.pop_front();
        if (got.new_temperature !== want.new_temperature)
            report_mismatch($sformatf("new_temperature at (%0d,%0d): got %0d want %0d",
                                      want.cell_row, want.cell_column,
                                      $signed(got.new_temperature),
                                      $signed(want.new_temperature)));
        if (got.cell_row !== want.cell_row)
            report_mismatch($sformatf("cell_row: got %0d want %0d",
                                      got.cell_row, want.cell_row));
        if (got.cell_column !== want.cell_column)
            report_mismatch($sformatf("cell_column: got %0d want %0d",
                                      got.cell_column, want.cell_column));
        if (got.frame_done !== want.frame_done)
            report_mismatch($sformatf("frame_done at (%0d,%0d): got %0b want %0b",
                                      want.cell_row, want.cell_column,
                                      got.frame_done, want.frame_done));
    endtask

    // Receiver: checks each output transaction, then picks next cycle's ready.
    // A requested hold-off keeps ready low for a counted stretch so that the
    // pipeline fills and the input side stalls.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            check_update(o_out_data);
        if (hold_off_left > 0) begin
            hold_off_left--;
            i_out_ready <= 1'b0;
        end else if (hold_off_request) begin
            hold_off_request = 1'b0;
            hold_off_left    = HOLD_OFF_CYCLES - 1;
            i_out_ready     <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL heat_diffusion_stencil_step_core");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Driving. Every task starts and ends just after a rising edge.
    // ------------------------------------------------------------------

    // Offer one cell, with an optional idle gap first. Valid is only dropped
    // for a gap, so back-to-back cells keep it high throughout.
    task automatic offer_cell(input logic [SAMPLE_BITS-1:0] temp, input logic first);
        t_hds_in txn;
        txn.temperature = temp;
        txn.frame_start = first;
        if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= txn;
        do @(posedge i_clk); while (!o_in_ready);
        advance_grid(temp, first);
    endtask

    // Stop offering and wait for every outstanding update to come back.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_updates.size() != 0);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_register(idx, data);
    endtask

    // Register writes only once the block is idle: drain, then allow for
    // boundary cells still in the pipeline that produce nothing.
    task automatic configure(input logic [CFG_DATA_W-1:0] cols_data,
                             input logic [CFG_DATA_W-1:0] rows_data,
                             input logic [CFG_DATA_W-1:0] gain_data);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        write_reg(CFG_GRID_WIDTH, cols_data);
        write_reg(CFG_GRID_HEIGHT, rows_data);
        write_reg(CFG_DIFFUSION_GAIN, gain_data);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [SAMPLE_BITS-1:0] pick_temperature();
        case ($urandom_range(9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2, 3, 4: return 16'($urandom);
            default: return 16'($urandom_range(0, 1023) - 512);
        endcase
    endfunction

    // Mostly small grids; some clamped sizes, with junk in the unused upper bits.
    function automatic logic [CFG_DATA_W-1:0] pick_cols_data();
        int unsigned v;
        case ($urandom_range(9))
            0:       v = $urandom_range(0, 2);
            1:       v = $urandom_range(65, 127);
            2:       v = MAX_WIDTH_DEF;
            default: v = $urandom_range(3, 12);
        endcase
        return 16'(v) | (($urandom_range(3) == 0) ? (16'($urandom) & 16'hFF80) : 16'h0);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_rows_data();
        int unsigned v;
        case ($urandom_range(9))
            0:       v = $urandom_range(0, 2);
            1:       v = $urandom_range(4097, 8191);
            2:       v = $urandom_range(20, 40);
            default: v = $urandom_range(3, 8);
        endcase
        return 16'(v) | (($urandom_range(3) == 0) ? (16'($urandom) & 16'hE000) : 16'h0);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_gain_data();
        case ($urandom_range(9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_random_cells(input int count, input bit with_start);
        for (int i = 0; i < count; i++)
            offer_cell(pick_temperature(), with_start && i == 0);
    endtask

    // One 4 x 3 frame from a fixed list of values, raster order.
    task automatic send_grid(input logic [SAMPLE_BITS-1:0] cells [12]);
        for (int i = 0; i < 12; i++)
            offer_cell(cells[i], i == 0);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Full gain; one interior cell is driven to positive saturation, the
    // other to negative saturation. Every bit of the sample toggles.
    task automatic test_saturation();
        logic [SAMPLE_BITS-1:0] cells [12];
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        cells = '{16'h7FFF, 16'h7FFF, 16'h8000, 16'h0000,
                  16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
                  16'h0000, 16'h7FFF, 16'h8000, 16'h0000};
        configure(16'd4, 16'd3, 16'hFFFF);
        send_grid(cells);
    endtask

    // Gain of one half makes every odd Laplacian an exact tie: -0.5 must
    // round to 0 and +0.5 to 1.
    task automatic test_tie_rounding();
        logic [SAMPLE_BITS-1:0] cells [12];
        cells = '{16'h0000, 16'hFFFF, 16'h0001, 16'h0000,
                  16'h0000, 16'h0000, 16'h0000, 16'h0000,
                  16'h0000, 16'h0000, 16'h0000, 16'h0000};
        configure(16'd4, 16'd3, 16'h8000);
        send_grid(cells);
    endtask

    // Widest grid reached by clamping from above, height clamped from below;
    // then the tallest grid, clamped from above at the narrowest width, of
    // which only the first rows are sent.
    task automatic test_size_extremes();
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        configure(16'hFFFF, 16'h0001, pick_gain_data());   // 127 -> 64, 1 -> 3
        send_random_cells(64 * 3, 1'b1);
        configure(16'h0000, 16'h1FFF, pick_gain_data());   // 0 -> 3, 8191 -> 4096
        send_random_cells(3 * 40, 1'b1);
    endtask

    // Long receiver hold-off while the sender keeps going, then a sender
    // pause mid-frame until every update is back, then the frame carries on.
    task automatic test_stall_and_pause();
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        configure(16'd8, 16'd6, pick_gain_data());
        hold_off_request = 1'b1;
        send_random_cells(100, 1'b1);
        wait_drained();
        send_random_cells(44, 1'b0);
    endtask

    // Random phases: fresh registers each phase, then mostly whole frames,
    // some following on without a start flag, some cut short by a new start.
    task automatic test_random_traffic(input int snd_pct, input int rcv_pct,
                                       input int items);
        int left;
        int budget;
        int full;
        int n;
        bit first;
        sender_idle_pct   = snd_pct;
        receiver_idle_pct = rcv_pct;
        left = items;
        while (left > 0) begin
            configure(pick_cols_data(), pick_rows_data(), pick_gain_data());
            budget = $urandom_range(30, 120);
            if (budget > left) budget = left;
            left -= budget;
            first = 1'b1;   // after a register change the first cell must restart
            while (budget > 0) begin
                full = eff_cols() * eff_rows();
                n    = ($urandom_range(9) < 2) ? $urandom_range(1, full - 1) : full;
                if (n > budget) n = budget;
                send_random_cells(n, first || $urandom_range(1));
                first = 1'b0;
                budget -= n;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_saturation();
        test_tie_rounding();
        test_size_extremes();
        test_stall_and_pause();
        test_random_traffic(32, 64, RANDOM_ITEMS / 3);
        test_random_traffic(64, 32, RANDOM_ITEMS / 3);
        test_random_traffic(0, 0, RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("PASS heat_diffusion_stencil_step_core");
        end else begin
            $display("FAIL heat_diffusion_stencil_step_core");
        end
        $finish;
    end

endmodule
